/* hdl/dwmd_pkg.sv */
// Shared constants for the distinct window marker detector.
package dwmd_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 14;
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned CFG_RESET      = 4;
  localparam int unsigned DATA_W         = 8;
  localparam int unsigned NUM_SYM        = 256;
  localparam int unsigned POS_W          = 16;
  localparam logic [POS_W-1:0] POS_MAX   = '1;

endpackage

/* hdl/dwmd_last_seen.sv */
// Last-seen index memory per byte value, with valid bits and an aging scrubber.
module dwmd_last_seen #(
  parameter int unsigned WINDOW_MAX = dwmd_pkg::WINDOW_MAX_DEF,
  parameter int unsigned IDX_W      = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [dwmd_pkg::DATA_W-1:0] wr_sym_i,
  input  logic [IDX_W-1:0]            wr_idx_i,
  output logic                        rd_seen_o,
  output logic [IDX_W-1:0]            rd_idx_o
);

  logic [IDX_W-1:0]            mem_q [dwmd_pkg::NUM_SYM];
  logic [dwmd_pkg::NUM_SYM-1:0] vld_q;
  logic [dwmd_pkg::NUM_SYM-1:0] vld_d;
  logic [IDX_W-1:0]            rd_idx_q;
  logic                        rd_seen_q;

  logic [dwmd_pkg::DATA_W-1:0] sc_ptr_q;
  logic [dwmd_pkg::DATA_W-1:0] sc_addr_q;
  logic [IDX_W-1:0]            sc_data_q;
  logic                        sc_live_q;
  logic [IDX_W-1:0]            sc_dist;
  logic                        sc_clear;

  // Entry age relative to the next index to be written; exact while the
  // scrubber keeps live entries younger than the index range.
  assign sc_dist  = wr_idx_i - sc_data_q;
  assign sc_clear = sc_live_q && (sc_dist >= IDX_W'(WINDOW_MAX));

  // Clear an aged entry, then mark the written one; a write wins.
  always_comb begin
    vld_d = vld_q;
    if (sc_clear) begin
      vld_d[sc_addr_q] = 1'b0;
    end
    if (wr_en_i) begin
      vld_d[wr_sym_i] = 1'b1;
    end
  end

  // Memory: one write port, lookup read port and scrub read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_sym_i] <= wr_idx_i;
      rd_idx_q        <= mem_q[wr_sym_i];
    end
    sc_data_q <= mem_q[sc_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_seen_q <= 1'b0;
      sc_ptr_q  <= '0;
      sc_addr_q <= '0;
      sc_live_q <= 1'b0;
    end else begin
      sc_ptr_q  <= sc_ptr_q + 1'b1;
      sc_addr_q <= sc_ptr_q;
      // drop the scrub check if this cycle rewrites the entry being read
      sc_live_q <= !(wr_en_i && (wr_sym_i == sc_ptr_q));
      vld_q     <= vld_d;
      if (wr_en_i) begin
        rd_seen_q <= vld_q[wr_sym_i];
      end
    end
  end

  assign rd_seen_o = rd_seen_q;
  assign rd_idx_o  = rd_idx_q;

`ifndef SYNTH
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> vld_q[$past(wr_sym_i)])
    else $error("written entry not marked valid");

  a_scrub_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_addr_q == $past(sc_ptr_q) |=> sc_addr_q == $past(sc_ptr_q))
    else $error("scrub address lost track of pointer");

  a_no_clear_on_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && (wr_sym_i == sc_ptr_q)) |=> !sc_clear)
    else $error("scrub cleared an entry written during its read");
`endif

endmodule

/* hdl/distinct_window_marker_detector.sv */
// A word is held in the lookup stage, then its result in the output register.
// One word per cycle when not stalled; last-seen memory read and written once per word.
// Reset: control state clears at once, window_len returns to 4, no clearing pass is run;
// per-value valid bits mark unwritten memory entries, and a scrubber ages out old ones.
// The end of a stream (last_byte) restarts run, position and marker state together.
// A result waits in the output register while the next word is taken in.
module distinct_window_marker_detector #(
  parameter int unsigned WINDOW_MAX = dwmd_pkg::WINDOW_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [dwmd_pkg::CFG_W-1:0]  cfg_data_i,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dwmd_pkg::DATA_W-1:0] data_byte_i,
  input  logic                        last_byte_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [dwmd_pkg::POS_W-1:0]  position_o
);

  // Byte index width: large enough that a live entry's age never wraps
  // between two scrub visits (WINDOW_MAX plus two scrub sweeps).
  localparam int unsigned IDX_W = $clog2(WINDOW_MAX + 2 * dwmd_pkg::NUM_SYM);
  localparam int unsigned RUN_W = $clog2(WINDOW_MAX + 1);

  logic [dwmd_pkg::CFG_W-1:0] cfg_q;

  // stage 1: lookup in flight
  logic             p1_valid_q;
  logic             p1_last_q;
  logic [IDX_W-1:0] p1_idx_q;
  logic [IDX_W-1:0] idx_q;
  logic             rd_seen;
  logic [IDX_W-1:0] rd_idx;

  // stream state
  logic [RUN_W-1:0]           run_q;
  logic [dwmd_pkg::POS_W-1:0] pos_q;
  logic                       marker_q;

  // output register
  logic                       out_valid_q;
  logic                       out_found_q;
  logic [dwmd_pkg::POS_W-1:0] out_pos_q;

  logic                       in_accept;
  logic                       advance;
  logic                       p1_take;
  logic [RUN_W-1:0]           len;
  logic [RUN_W-1:0]           keep;
  logic [IDX_W-1:0]           rep_dist;
  logic                       hit;
  logic [RUN_W-1:0]           new_run;
  logic [dwmd_pkg::POS_W-1:0] pos_next;
  logic                       emit_found;
  logic                       emit_miss;

  // Output register free or leaving: the lookup stage may retire.
  assign advance    = !out_valid_q || !out_stall_i;
  assign p1_take    = p1_valid_q && advance;
  assign in_stall_o = p1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Window length: zero acts as one, large values saturate.
  always_comb begin
    if (cfg_q == '0) begin
      len = RUN_W'(1);
    end else if (int'(cfg_q) > int'(WINDOW_MAX)) begin
      len = RUN_W'(WINDOW_MAX);
    end else begin
      len = RUN_W'(cfg_q);
    end
  end

  // The nearest repeat of this byte bounds the run. Indices never restart,
  // so a repeat from an earlier stream is always farther than the run.
  assign keep       = (run_q > len - 1'b1) ? len - 1'b1 : run_q;
  assign rep_dist   = p1_idx_q - rd_idx;
  assign hit        = rd_seen && (rep_dist <= IDX_W'(keep));
  assign new_run    = hit ? RUN_W'(rep_dist) : keep + 1'b1;
  assign pos_next   = (pos_q == dwmd_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
  assign emit_found = !marker_q && (new_run >= len);
  assign emit_miss  = !marker_q && p1_last_q && !emit_found;

  dwmd_last_seen #(
    .WINDOW_MAX (WINDOW_MAX),
    .IDX_W      (IDX_W)
  ) u_last_seen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_accept),
    .wr_sym_i  (data_byte_i),
    .wr_idx_i  (idx_q),
    .rd_seen_o (rd_seen),
    .rd_idx_o  (rd_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dwmd_pkg::CFG_W'(dwmd_pkg::CFG_RESET);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Lookup stage: hold the word's index while the memory read completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (in_accept) begin
        p1_valid_q <= 1'b1;
        idx_q      <= idx_q + 1'b1;
      end else if (p1_take) begin
        p1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p1_last_q <= last_byte_i;
      p1_idx_q  <= idx_q;
    end
  end

  // Run update and result generation; restart the stream after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      pos_q       <= '0;
      marker_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result, hold a stalled one, or drop the one that left
      out_valid_q <= (p1_take && (emit_found || emit_miss)) ||
                     (out_valid_q && out_stall_i);
      if (p1_take) begin
        if (p1_last_q) begin
          run_q    <= '0;
          pos_q    <= '0;
          marker_q <= 1'b0;
        end else begin
          run_q    <= new_run;
          pos_q    <= pos_next;
          marker_q <= marker_q || emit_found;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_take && (emit_found || emit_miss)) begin
      out_found_q <= emit_found;
      out_pos_q   <= pos_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign position_o  = out_pos_q;

`ifndef SYNTH
  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= RUN_W'(WINDOW_MAX))
    else $error("run length beyond window store");

  a_marker_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(marker_q) |-> out_valid_o && found_o)
    else $error("marker set without a found result");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> p1_valid_q && out_valid_q)
    else $error("input stalled with nothing in flight");

  a_marker_has_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    marker_q |-> pos_q != '0)
    else $error("marker seen at position zero");
`endif

endmodule

/* tb/sv/dwmd_marker_checker.sv */
// Checker for the distinct window marker detector: predicts marker reports and compares them.
`timescale 1ns / 100ps

module dwmd_marker_checker #(
  parameter int unsigned WINDOW_MAX = dwmd_pkg::WINDOW_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dwmd_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [dwmd_pkg::DATA_W-1:0] data_byte_i,
  input  logic                        last_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        found_i,
  input  logic [dwmd_pkg::POS_W-1:0]  position_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  typedef struct packed {
    logic                       found;
    logic [dwmd_pkg::POS_W-1:0] position;
  } marker_report_t;

  logic [dwmd_pkg::DATA_W-1:0] recent [WINDOW_MAX];
  logic [dwmd_pkg::CFG_W-1:0]  window_len;
  logic [dwmd_pkg::POS_W-1:0]  stream_pos;
  int                          run_len;
  bit                          marker_hit;
  marker_report_t              expected_reports [$];
  marker_report_t              want;
  int                          fails;
  int                          checked;

  task automatic restart_stream();
    int k;
    for (k = 0; k < WINDOW_MAX; k++) recent[k] = '0;
    run_len    = 0;
    stream_pos = '0;
    marker_hit = 1'b0;
  endtask

  // Advance the stream state by one accepted word and queue the report it causes.
  task automatic predict_marker(input logic [dwmd_pkg::DATA_W-1:0] b, input logic is_last);
    int             len;
    int             keep;
    int             new_run;
    int             k;
    bit             hit;
    marker_report_t fresh;
    len = int'(window_len);
    if (len < 1) len = 1;
    if (len > int'(WINDOW_MAX)) len = int'(WINDOW_MAX);
    // cap the run at one less than the current length before comparing
    keep = run_len;
    if (keep > len - 1) keep = len - 1;
    new_run = keep + 1;
    hit = 1'b0;
    for (k = 0; k < keep; k++) begin
      if (!hit && recent[k] == b) begin
        new_run = k + 1;
        hit     = 1'b1;
      end
    end
    for (k = WINDOW_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = b;
    run_len = new_run;
    if (stream_pos != dwmd_pkg::POS_MAX) stream_pos = stream_pos + 1'b1;
    if (!marker_hit && run_len >= len) begin
      marker_hit     = 1'b1;
      fresh.found    = 1'b1;
      fresh.position = stream_pos;
      expected_reports.push_back(fresh);
    end else if (is_last && !marker_hit) begin
      fresh.found    = 1'b0;
      fresh.position = stream_pos;
      expected_reports.push_back(fresh);
    end
    if (is_last) restart_stream();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len = dwmd_pkg::CFG_W'(dwmd_pkg::CFG_RESET);
      restart_stream();
      expected_reports.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("result word with no report expected: found %0d position %0d",
                 found_i, position_i);
          fails++;
        end else begin
          want = expected_reports.pop_front();
          checked++;
          if (found_i !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found_i);
            fails++;
          end
          if (position_i !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) window_len = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_marker(data_byte_i, last_byte_i);
    end
    fail_count_o <= fails;
    pending_o    <= expected_reports.size();
    checked_o    <= checked;
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the distinct window marker detector test: stimulus, stall patterns and verdict.
`timescale 1ns / 100ps

module testbench;

  // Cycles to let pass after the last report before touching the register:
  // a word that causes no report may still sit in the two-stage pipe.
  localparam int SETTLE_CYCLES = 6;
  // Long receiver hold-off, long enough for the block to back up its input.
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_WORDS  = 1650;
  // Hard stop, several times the slowest legal run.
  localparam int LIMIT_NS      = 3_000_000;

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [dwmd_pkg::CFG_W-1:0]  cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic [dwmd_pkg::DATA_W-1:0] data_byte = '0;
  logic                        last_byte = 1'b0;
  logic                        rx_stall  = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic                        found;
  logic [dwmd_pkg::POS_W-1:0]  position;

  int fail_count;
  int pending;
  int checked;
  int words_sent   = 0;
  int streams_sent = 0;
  int cfg_writes   = 0;

  // Idling controls for the sender and the receiver process.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;

  distinct_window_marker_detector #(
    .WINDOW_MAX (dwmd_pkg::WINDOW_MAX_DEF)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid),
    .out_stall_i (rx_stall),
    .found_o     (found),
    .position_o  (position)
  );

  dwmd_marker_checker #(
    .WINDOW_MAX (dwmd_pkg::WINDOW_MAX_DEF)
  ) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .data_byte_i  (data_byte),
    .last_byte_i  (last_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (rx_stall),
    .found_i      (found),
    .position_i   (position),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or a report never shows up.
  initial begin
    #(LIMIT_NS);
    $display("distinct_window_marker_detector test failed");
    $finish;
  end

  // Gap length: mostly none, often a few cycles, rarely a long stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: alternate runs of ready and stalled cycles. A hold request
  // from the stimulus turns into one long stall counted here.
  initial begin
    int ready_run;
    int stall_run;
    forever begin
      if (hold_req) begin
        ready_run = 1;
        stall_run = HOLD_CYCLES;
        hold_req  = 1'b0;
      end else if (rx_steady) begin
        ready_run = 1 + pick_gap();
        stall_run = 0;
      end else begin
        ready_run = 1 + pick_gap();
        stall_run = pick_gap();
      end
      repeat (ready_run) begin
        @(posedge clk);
        rx_stall <= 1'b0;
      end
      repeat (stall_run) begin
        @(posedge clk);
        rx_stall <= 1'b1;
      end
    end
  end

  // Offer one word after an optional gap and hold it until the block takes it.
  // Return right after the accepting edge, so back-to-back words keep valid high.
  task automatic send_word(input logic [dwmd_pkg::DATA_W-1:0] b, input logic is_last);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (is_last) streams_sent++;
  endtask

  // Drop valid, wait until every expected report has arrived, then let the
  // pipe run empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window length with the block idle; a stream may still be open.
  task automatic write_window(input logic [dwmd_pkg::CFG_W-1:0] len);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int                          plan [4];
    int                          rand_words;
    int                          phase;
    int                          win;
    int                          eff;
    int                          budget;
    int                          kind;
    int                          slen;
    int                          asz;
    int                          k;
    logic [dwmd_pkg::DATA_W-1:0] base;

    plan = '{0, 15, 1, 14};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // ---- directed words, window length 4 from reset ----
    // marker completes on the final word of the stream, extreme byte values
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b1);
    // stream shorter than the window ends without a marker
    send_word(8'h12, 1'b0);
    send_word(8'h34, 1'b1);
    // repeats first, then a marker, then words after the marker stay silent
    send_word(8'h05, 1'b0);
    send_word(8'h05, 1'b0);
    send_word(8'h05, 1'b0);
    send_word(8'h05, 1'b0);
    send_word(8'h06, 1'b0);
    send_word(8'h07, 1'b0);
    send_word(8'h08, 1'b0);
    send_word(8'h09, 1'b0);
    send_word(8'h09, 1'b1);
    // single-word stream, no marker
    send_word(8'h55, 1'b1);
    // zero length acts as one: every first word is a marker
    write_window(4'd0);
    send_word(8'hAA, 1'b1);
    // length above the maximum saturates; short stream with a repeat
    write_window(4'd15);
    send_word(8'h01, 1'b0);
    send_word(8'h01, 1'b1);
    // shrink the window in the middle of a stream: the run is cut at once
    send_word(8'h01, 1'b0);
    send_word(8'h02, 1'b0);
    send_word(8'h03, 1'b0);
    write_window(4'd2);
    send_word(8'h04, 1'b0);
    send_word(8'h05, 1'b1);

    // ---- back-pressure: hold the receiver while one-word streams pour in ----
    write_window(4'd1);
    tx_steady = 1'b1;
    hold_req  = 1'b1;
    wait (!hold_req);
    for (k = 0; k < 60; k++) send_word(dwmd_pkg::DATA_W'(k * 37), 1'b1);
    tx_steady = 1'b0;
    // the next write pauses the sender until every report is back

    // ---- random phases, one window length each ----
    rand_words = 0;
    phase      = 0;
    base       = '0;
    while (rand_words < RANDOM_WORDS) begin
      win = (phase < 4) ? plan[phase] : $urandom_range(0, 15);
      write_window(dwmd_pkg::CFG_W'(win));
      eff = (win < 1) ? 1 : win;
      if (eff > int'(dwmd_pkg::WINDOW_MAX_DEF)) eff = int'(dwmd_pkg::WINDOW_MAX_DEF);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      budget    = $urandom_range(80, 220);
      while (budget > 0) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          // noise: any byte, stream ends at random
          slen = $urandom_range(1, 8);
          for (k = 0; k < slen; k++)
            send_word(dwmd_pkg::DATA_W'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
        end else begin
          // well-formed stream over a small or a wide alphabet
          slen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
                                             : $urandom_range(1, 2 * eff + 6);
          asz  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, eff + 3)
                                             : $urandom_range(eff, 255);
          base = dwmd_pkg::DATA_W'($urandom_range(0, 255));
          for (k = 0; k < slen; k++)
            send_word(dwmd_pkg::DATA_W'(base + $urandom_range(0, asz - 1)), k == slen - 1);
        end
        budget     -= slen;
        rand_words += slen;
      end
      // leave a stream open now and then, so the next write lands mid-stream
      if ($urandom_range(0, 1) == 1) begin
        slen = $urandom_range(1, 6);
        for (k = 0; k < slen; k++)
          send_word(dwmd_pkg::DATA_W'(base + $urandom_range(0, 7)), 1'b0);
        rand_words += slen;
      end
      phase++;
    end

    // close any open stream, then drain
    send_word(dwmd_pkg::DATA_W'($urandom_range(0, 255)), 1'b1);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    settle();

    $display("Checked %0d marker reports from %0d words in %0d streams,",
             checked, words_sent, streams_sent);
    $display("over %0d window length writes from 0 to 15, with a held receiver.",
             cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("distinct_window_marker_detector test passed");
    end else begin
      $display("distinct_window_marker_detector test failed");
    end
    $finish;
  end

endmodule
